@@ rtl/attributed_csr_register_bank_unit_macros.svh @@
// Assertion macros for the attributed CSR register bank.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef ATTRIBUTED_CSR_REGISTER_BANK_UNIT_MACROS_SVH
`define ATTRIBUTED_CSR_REGISTER_BANK_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Property holds at every clock edge outside reset.
`define ACSR_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// Condition never holds outside reset.
`define ACSR_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ACSR_ASSERT(name, prop)
`define ACSR_ASSERT_NEVER(name, cond)
`endif

`endif

@@ rtl/acsr_pkg.sv @@
// Shared types, constants and helpers of the attributed CSR register bank.
// No dependencies.
package acsr_pkg;

  localparam int NumRegs   = 64;
  localparam int RegBytes  = 4;
  localparam int DataW     = 32;
  localparam int AddrW     = 16;
  localparam int SlotShift = $clog2(RegBytes);
  localparam int IdxW      = (NumRegs > 1) ? $clog2(NumRegs) : 1;

  typedef enum logic [1:0] {
    CmdRead     = 2'd0,
    CmdWrite    = 2'd1,
    CmdResetAll = 2'd2,
    CmdDefine   = 2'd3
  } cmd_e;

  typedef enum logic {
    StIdle = 1'b0,
    StExec = 1'b1
  } state_e;

  typedef struct packed {
    cmd_e             command;
    logic [AddrW-1:0] address;
    logic [3:0]       access_size;
    logic [DataW-1:0] write_value;
    logic [DataW-1:0] reset_value;
    logic [DataW-1:0] readonly_mask;
    logic [DataW-1:0] clear_on_write_one_mask;
    logic [DataW-1:0] clear_on_read_mask;
    logic [DataW-1:0] reserved_mask;
    logic [DataW-1:0] unimplemented_mask;
  } req_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic             status;
    logic             reserved_changed;
    logic             unimplemented_written;
  } rsp_t;

  // Per-slot attributes, stored as one memory word.
  typedef struct packed {
    logic [DataW-1:0] rst_value;
    logic [DataW-1:0] ro;
    logic [DataW-1:0] w1c;
    logic [DataW-1:0] cor;
    logic [DataW-1:0] rsvd;
    logic [DataW-1:0] unimp;
  } attr_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;  // latch request, start memory read
    logic commit;   // update state, load result register
  } ctrl_cmd_t;

  // Mask of the low n bytes of a data word.
  function automatic logic [DataW-1:0] bytes_mask(logic [3:0] n);
    logic [DataW-1:0] m;
    m = '0;
    for (int b = 0; b < DataW / 8; b++) begin
      m[8*b +: 8] = (4'(b) < n) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

  localparam logic [DataW-1:0] WidthMask = bytes_mask(4'(RegBytes));

endpackage

@@ rtl/acsr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module acsr_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/acsr_ctrl.sv @@
// Controller of the attributed CSR register bank: request handshake,
// two-state sequencer and result valid. Depends on acsr_pkg.
module acsr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output acsr_pkg::ctrl_cmd_t cmd_o
);
  import acsr_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    out_valid_d   = out_valid_q && !out_ready_i;
    case (state_q)
      StIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = StExec;
        end
      end
      StExec: begin
        // hold until the result register can take the response
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/acsr_datapath.sv @@
// Datapath of the attributed CSR register bank: request register, value and
// attribute memories, per-slot flags, mask logic and result register.
// Depends on acsr_pkg and acsr_ram.
module acsr_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  acsr_pkg::ctrl_cmd_t cmd_i,
  input  acsr_pkg::req_t      in_req_i,
  output acsr_pkg::rsp_t      rsp_o
);
  import acsr_pkg::*;

  localparam logic [AddrW-1:0] AlignMask = AddrW'(RegBytes - 1);
  localparam logic [AddrW-1:0] SlotLimit = AddrW'(NumRegs);

  req_t             req_q;
  rsp_t             rsp_q, rsp_d;
  logic [NumRegs-1:0] defined_q, defined_d;
  logic [NumRegs-1:0] at_rst_q, at_rst_d;

  logic [AddrW-1:0] slot_full;
  logic [IdxW-1:0]  idx, in_idx;
  logic             mapped, hit;
  logic [3:0]       size_c;
  logic [DataW-1:0] en, old, no_write, nv;
  logic [DataW-1:0] reg_rd, reg_wdata;
  attr_t            attr_rd, attr_wdata;
  logic             reg_upd, attr_upd, rst_all;

  assign in_idx = IdxW'(in_req_i.address >> SlotShift);

  acsr_ram #(.Width(DataW), .Depth(NumRegs)) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit && reg_upd),
    .waddr_i (idx),
    .wdata_i (reg_wdata),
    .re_i    (cmd_i.capture),
    .raddr_i (in_idx),
    .rdata_o (reg_rd)
  );

  acsr_ram #(.Width($bits(attr_t)), .Depth(NumRegs)) u_attr_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit && attr_upd),
    .waddr_i (idx),
    .wdata_i (attr_wdata),
    .re_i    (cmd_i.capture),
    .raddr_i (in_idx),
    .rdata_o (attr_rd)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= in_req_i;
    end
    if (cmd_i.commit) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      defined_q <= '0;
      at_rst_q  <= '0;
    end else if (cmd_i.commit) begin
      defined_q <= defined_d;
      at_rst_q  <= at_rst_d;
    end
  end

  always_comb begin
    slot_full = req_q.address >> SlotShift;
    idx       = slot_full[IdxW-1:0];
    mapped    = ((req_q.address & AlignMask) == '0) && (slot_full < SlotLimit);
    hit       = mapped && defined_q[idx];
    size_c    = (req_q.access_size > 4'(RegBytes)) ? 4'(RegBytes) : req_q.access_size;
    en        = bytes_mask(size_c);
    // a slot marked at reset value reads its stored reset value
    old       = at_rst_q[idx] ? attr_rd.rst_value : reg_rd;
    no_write  = attr_rd.ro | attr_rd.w1c | attr_rd.rsvd | ~en;
    nv        = (req_q.write_value & ~no_write) | (old & no_write);
    nv        = nv & ~(req_q.write_value & attr_rd.w1c);

    attr_wdata.rst_value = req_q.reset_value & WidthMask;
    attr_wdata.ro        = req_q.readonly_mask & WidthMask;
    attr_wdata.w1c       = req_q.clear_on_write_one_mask & WidthMask;
    attr_wdata.cor       = req_q.clear_on_read_mask & WidthMask;
    attr_wdata.rsvd      = req_q.reserved_mask & WidthMask;
    attr_wdata.unimp     = req_q.unimplemented_mask & WidthMask;

    rsp_d     = '0;
    reg_wdata = old;
    reg_upd   = 1'b0;
    attr_upd  = 1'b0;
    rst_all   = 1'b0;
    defined_d = defined_q;
    at_rst_d  = at_rst_q;

    case (req_q.command)
      CmdRead: begin
        if (hit) begin
          rsp_d.read_data = old & en;
          reg_wdata       = old & ~(attr_rd.cor & en);
          reg_upd         = 1'b1;
        end else begin
          rsp_d.status = 1'b1;
        end
      end
      CmdWrite: begin
        if (hit) begin
          rsp_d.reserved_changed      = |((old ^ req_q.write_value) & attr_rd.rsvd);
          rsp_d.unimplemented_written = |(req_q.write_value & attr_rd.unimp);
          reg_wdata                   = nv & WidthMask;
          reg_upd                     = 1'b1;
        end else begin
          rsp_d.status = 1'b1;
        end
      end
      CmdResetAll: begin
        // undefined slots are never read, so flag every slot
        rst_all = 1'b1;
      end
      CmdDefine: begin
        if (mapped) begin
          attr_upd = 1'b1;
        end else begin
          rsp_d.status = 1'b1;
        end
      end
      default: begin
        rsp_d.status = 1'b1;
      end
    endcase

    if (rst_all) begin
      at_rst_d = '1;
    end else if (attr_upd) begin
      at_rst_d[idx]  = 1'b1;
      defined_d[idx] = 1'b1;
    end else if (reg_upd) begin
      at_rst_d[idx] = 1'b0;
    end
  end

  assign rsp_o = rsp_q;

endmodule

@@ rtl/attributed_csr_register_bank_unit.sv @@
// Attributed CSR register bank, top level. The value and attribute memories
// are read and the request is registered at the accepting edge; in StExec the
// commit then updates the state and registers the response, which shows as valid.
// No new request is taken until the previous one is committed; a response
// held by out_ready_i low stalls the request in execution until it drains.
// Reset clears the slot-defined and at-reset flags at once; no clearing pass.
module attributed_csr_register_bank_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  acsr_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output acsr_pkg::rsp_t out_rsp_o
);
  import acsr_pkg::*;

  ctrl_cmd_t cmd;
  logic      rsp_quiet;

  acsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  acsr_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .in_req_i (in_req_i),
    .rsp_o    (out_rsp_o)
  );

  assign rsp_quiet = (out_rsp_o.read_data == '0) && !out_rsp_o.reserved_changed &&
                     !out_rsp_o.unimplemented_written;

`include "attributed_csr_register_bank_unit_macros.svh"

  `ACSR_ASSERT(a_no_back_to_back, (in_valid_i && in_ready_o) |=> !in_ready_o)
  `ACSR_ASSERT(a_commit_shows_result, cmd.commit |=> out_valid_o)
  `ACSR_ASSERT_NEVER(a_capture_commit_overlap, cmd.capture && cmd.commit)
  `ACSR_ASSERT(a_unmapped_quiet, (out_valid_o && out_rsp_o.status) |-> rsp_quiet)

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for attributed_csr_register_bank_unit: directed and random CSR requests,
// checked against a predictor of the attribute masks. Depends on acsr_pkg and the DUT.

class csr_bank_tracker;
  logic [31:0] value_q[acsr_pkg::NumRegs];
  logic [31:0] rst_q[acsr_pkg::NumRegs];
  logic [31:0] ro_q[acsr_pkg::NumRegs];
  logic [31:0] w1c_q[acsr_pkg::NumRegs];
  logic [31:0] cor_q[acsr_pkg::NumRegs];
  logic [31:0] rsvd_q[acsr_pkg::NumRegs];
  logic [31:0] unimp_q[acsr_pkg::NumRegs];
  bit          slot_live[acsr_pkg::NumRegs];
  acsr_pkg::rsp_t expected_rsps[$];
  int errors, n_read, n_write, n_reset, n_define, n_unmapped, n_flagged;

  function new();
    foreach (value_q[i]) begin
      value_q[i] = '0;
      rst_q[i]   = '0;
      ro_q[i]    = '0;
      w1c_q[i]   = '0;
      cor_q[i]   = '0;
      rsvd_q[i]  = '0;
      unimp_q[i] = '0;
      slot_live[i] = 1'b0;
    end
  endfunction

  function logic [31:0] lane_mask(int nbytes);
    if (nbytes >= 4) return '1;
    return (32'h1 << (8 * nbytes)) - 32'h1;
  endfunction

  function acsr_pkg::rsp_t apply_access(acsr_pkg::req_t r);
    acsr_pkg::rsp_t rsp;
    int slot;
    bit mapped;
    logic [31:0] wmask, en, old, hold, nv;
    rsp    = '0;
    slot   = int'(r.address) / acsr_pkg::RegBytes;
    mapped = (int'(r.address) % acsr_pkg::RegBytes == 0) && (slot < acsr_pkg::NumRegs);
    wmask  = lane_mask(acsr_pkg::RegBytes);
    case (r.command)
      acsr_pkg::CmdResetAll: begin
        foreach (value_q[i]) if (slot_live[i]) value_q[i] = rst_q[i];
      end
      acsr_pkg::CmdDefine: begin
        if (!mapped) begin
          rsp.status = 1'b1;
        end else begin
          rst_q[slot]     = r.reset_value & wmask;
          ro_q[slot]      = r.readonly_mask & wmask;
          w1c_q[slot]     = r.clear_on_write_one_mask & wmask;
          cor_q[slot]     = r.clear_on_read_mask & wmask;
          rsvd_q[slot]    = r.reserved_mask & wmask;
          unimp_q[slot]   = r.unimplemented_mask & wmask;
          slot_live[slot] = 1'b1;
          value_q[slot]   = rst_q[slot];
        end
      end
      default: begin
        if (!mapped || !slot_live[slot]) begin
          rsp.status = 1'b1;
        end else begin
          // clamp the access to the register width
          en  = lane_mask((int'(r.access_size) > acsr_pkg::RegBytes) ?
                          acsr_pkg::RegBytes : int'(r.access_size));
          old = value_q[slot];
          if (r.command == acsr_pkg::CmdRead) begin
            value_q[slot] = old & ~(cor_q[slot] & en);
            rsp.read_data = old & en;
          end else begin
            rsp.reserved_changed      = |((old ^ r.write_value) & rsvd_q[slot]);
            rsp.unimplemented_written = |(r.write_value & unimp_q[slot]);
            hold = ro_q[slot] | w1c_q[slot] | rsvd_q[slot] | ~en;
            nv   = (r.write_value & ~hold) | (old & hold);
            // w1c clears ignore the byte lanes
            nv  &= ~(r.write_value & w1c_q[slot]);
            value_q[slot] = nv & wmask;
          end
        end
      end
    endcase
    return rsp;
  endfunction

  function void note_request(acsr_pkg::req_t r);
    case (r.command)
      acsr_pkg::CmdRead:     n_read++;
      acsr_pkg::CmdWrite:    n_write++;
      acsr_pkg::CmdResetAll: n_reset++;
      default:               n_define++;
    endcase
    expected_rsps.push_back(apply_access(r));
  endfunction

  function void check_result(acsr_pkg::rsp_t got);
    acsr_pkg::rsp_t want;
    if (expected_rsps.size() == 0) begin
      $error("response with no request outstanding: %p", got);
      errors++;
      return;
    end
    want = expected_rsps.pop_front();
    if (got.status) n_unmapped++;
    if (got.reserved_changed || got.unimplemented_written) n_flagged++;
    if (got.read_data !== want.read_data) begin
      $error("read_data: expected %0h, got %0h", want.read_data, got.read_data);
      errors++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0b, got %0b", want.status, got.status);
      errors++;
    end
    if (got.reserved_changed !== want.reserved_changed) begin
      $error("reserved_changed: expected %0b, got %0b",
             want.reserved_changed, got.reserved_changed);
      errors++;
    end
    if (got.unimplemented_written !== want.unimplemented_written) begin
      $error("unimplemented_written: expected %0b, got %0b",
             want.unimplemented_written, got.unimplemented_written);
      errors++;
    end
  endfunction

  function int pending();
    return expected_rsps.size();
  endfunction
endclass

module testbench;
  import acsr_pkg::*;

  localparam int RandomItems = 650;
  localparam int CycleLimit  = 200000;

  logic clk_i     = 1'b0;
  logic rst_ni    = 1'b0;
  logic in_valid  = 1'b0;
  logic out_ready = 1'b0;
  req_t in_req    = '0;
  logic in_ready;
  logic out_valid;
  rsp_t out_rsp;

  csr_bank_tracker board = new();

  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int cycles     = 0;

  attributed_csr_register_bank_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) board.check_result(out_rsp);
  end

  // Receiver: switch between always ready, random, sparse and long stalls.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(8, 60);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      2:       out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (stall_left < 2);
    endcase
  end

  function automatic logic [31:0] pattern_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return $urandom() & $urandom();
      3:       return $urandom() & $urandom() & $urandom();
      default: return $urandom();
    endcase
  endfunction

  function automatic req_t random_req();
    req_t r;
    int pick;
    int slot;
    pick = $urandom_range(0, 99);
    if (pick < 38)      r.command = CmdRead;
    else if (pick < 76) r.command = CmdWrite;
    else if (pick < 95) r.command = CmdDefine;
    else                r.command = CmdResetAll;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      r.address = 16'($urandom_range(0, 16'hFFFF));
    end else begin
      // hot slots at both ends of the bank get most of the traffic
      slot = $urandom_range(0, 15);
      slot = (slot < 8) ? slot : slot + NumRegs - 16;
      if (pick >= 85) slot = $urandom_range(0, NumRegs - 1);
      r.address = 16'(slot * RegBytes);
    end
    pick = $urandom_range(0, 99);
    if (pick < 70)      r.access_size = 4'($urandom_range(1, 4));
    else if (pick < 82) r.access_size = 4'd0;
    else                r.access_size = 4'($urandom_range(5, 15));
    r.write_value             = pattern_word();
    r.reset_value             = pattern_word();
    r.readonly_mask           = pattern_word();
    r.clear_on_write_one_mask = pattern_word();
    r.clear_on_read_mask      = pattern_word();
    r.reserved_mask           = pattern_word();
    r.unimplemented_mask      = pattern_word();
    return r;
  endfunction

  function automatic req_t access_req(cmd_e c, int addr, int size, logic [31:0] wval);
    req_t r;
    r = random_req();
    r.command     = c;
    r.address     = 16'(addr);
    r.access_size = 4'(size);
    r.write_value = wval;
    return r;
  endfunction

  function automatic req_t define_req(int addr, logic [31:0] rv, logic [31:0] ro,
                                      logic [31:0] w1c, logic [31:0] cor,
                                      logic [31:0] rsvd, logic [31:0] unimp);
    req_t r;
    r = random_req();
    r.command                 = CmdDefine;
    r.address                 = 16'(addr);
    r.reset_value             = rv;
    r.readonly_mask           = ro;
    r.clear_on_write_one_mask = w1c;
    r.clear_on_read_mask      = cor;
    r.reserved_mask           = rsvd;
    r.unimplemented_mask      = unimp;
    return r;
  endfunction

  // Hold valid and payload until accepted, then keep the burst going or drop valid.
  task automatic send_request(input req_t r);
    in_req   <= r;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    board.note_request(r);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(0, 12);
    end
  endtask

  task automatic wait_for_responses();
    // drop valid only when a burst left it high
    if (in_valid) in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // undefined slot
    send_request(access_req(CmdRead, 0, 4, '0));
    send_request(access_req(CmdWrite, 0, 4, '1));
    send_request(define_req(0, 32'hA5A5_5A5A, 32'h0000_00F0, 32'h0000_0F00,
                            32'h0000_F000, 32'h000F_0000, 32'hF000_0000));
    send_request(access_req(CmdRead, 0, 4, '0));
    send_request(access_req(CmdWrite, 0, 4, '1));
    send_request(access_req(CmdRead, 0, 2, '0));
    // zero size: only w1c clears take effect
    send_request(access_req(CmdWrite, 0, 0, 32'h0000_0F0F));
    send_request(access_req(CmdRead, 0, 0, '0));
    // oversized accesses clamp to the register width
    send_request(access_req(CmdWrite, 0, 15, '0));
    send_request(access_req(CmdRead, 0, 8, '0));
    send_request(define_req((NumRegs - 1) * RegBytes, '1, '0, '0, '0, '0, '0));
    send_request(access_req(CmdWrite, (NumRegs - 1) * RegBytes, 1, 32'h1234_5678));
    send_request(access_req(CmdRead, (NumRegs - 1) * RegBytes, 3, '0));
    // unaligned and out-of-range addresses
    send_request(access_req(CmdRead, 1, 4, '0));
    send_request(access_req(CmdWrite, 16'hFFFF, 4, '1));
    send_request(define_req(2, '1, '0, '0, '0, '0, '0));
    send_request(access_req(CmdRead, NumRegs * RegBytes, 4, '0));
    send_request(define_req(16'hFFFC, '1, '1, '1, '1, '1, '1));
    send_request(access_req(CmdWrite, 16'h8000, 4, '1));
    send_request(define_req(RegBytes, '0, '1, '1, '1, '1, '1));
    send_request(access_req(CmdWrite, RegBytes, 4, '1));
    send_request(access_req(CmdRead, RegBytes, 4, '0));
    send_request(access_req(CmdResetAll, 16'hFFFF, 4, '0));
    send_request(access_req(CmdRead, 0, 4, '0));
    send_request(access_req(CmdRead, (NumRegs - 1) * RegBytes, 4, '0));
    wait_for_responses();

    for (int n = 0; n < RandomItems; n++) begin
      if (n % 160 == 80) wait_for_responses();
      send_request(random_req());
    end

    wait_for_responses();
    repeat (8) @(posedge clk_i);
    $display("Covered %0d reads, %0d writes, %0d slot defines, %0d bank resets.",
             board.n_read, board.n_write, board.n_define, board.n_reset);
    $display("Responses: %0d unmapped or undefined, %0d with warning flags set.",
             board.n_unmapped, board.n_flagged);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/acsr_pkg.sv
rtl/acsr_ram.sv
rtl/acsr_ctrl.sv
rtl/acsr_datapath.sv
rtl/attributed_csr_register_bank_unit.sv
tb/testbench.sv
